// ===== hw/rtl/tsfa_pkg.sv =====
// Shared constants and types for the temperature sample filter, scaler and alarm block.
package tsfa_pkg;

	localparam int SampleBitsDef = 16;
	localparam int CodeW = 16;
	localparam int TenthsW = 10;
	localparam int DigitW = 4;

	localparam logic [CodeW-1:0] AlarmLimitRst = 16'd15000;

	// FIR taps, newest first: 10, 15, 50, 15, 10
	localparam int TapOuter = 10;
	localparam int TapInner = 15;
	localparam int TapMid = 50;

	localparam int SumW = 23;
	localparam int ProdW = 47;
	localparam int RecipW = 24;

	// sum / 100 = (sum * FirRecip) >> FirShift, exact for sum < 2^30 / 76
	localparam logic [RecipW-1:0] FirRecip = 24'd10737419;
	localparam int FirShift = 30;

	// tenths = (50 v + 3124962) / 12500, reciprocal exact for n < 2^37 / 9028
	localparam int TempScale = 50;
	localparam int TempOffset = 3124962;
	localparam logic [RecipW-1:0] TempRecip = 24'd10995117;
	localparam int TempShift = 37;

	// decimal split of tenths below 1000
	localparam int HundRecip = 41;
	localparam int HundShift = 12;
	localparam int TensRecip = 205;
	localparam int TensShift = 11;

	localparam int QDepth = 4;

	typedef struct packed {
		logic             valid;
		logic [CodeW-1:0] code;
	} q_entry_t;

endpackage

// ===== hw/rtl/tsfa_if.sv =====
// Channel interfaces: sample input, result output and limit configuration.
interface tsfa_in_if;
	logic                        valid;
	logic                        ready;
	logic [tsfa_pkg::CodeW-1:0]  sample;
	logic                        sample_valid;

	modport source(output valid, sample, sample_valid, input ready);
	modport sink(input valid, sample, sample_valid, output ready);
endinterface

interface tsfa_out_if;
	logic                          valid;
	logic                          ready;
	logic [tsfa_pkg::CodeW-1:0]    filtered_code;
	logic [tsfa_pkg::TenthsW-1:0]  temp_tenths;
	logic [tsfa_pkg::DigitW-1:0]   digit_hundreds;
	logic [tsfa_pkg::DigitW-1:0]   digit_tens;
	logic [tsfa_pkg::DigitW-1:0]   digit_units;
	logic                          high_temp;

	modport source(output valid, filtered_code, temp_tenths, digit_hundreds, digit_tens,
		digit_units, high_temp, input ready);
	modport sink(input valid, filtered_code, temp_tenths, digit_hundreds, digit_tens,
		digit_units, high_temp, output ready);
endinterface

interface tsfa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tsfa_pkg::CodeW-1:0]  data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/tsfa_front.sv =====
// Front end: 5-tap FIR with divide by 100, invalid-sample substitution, queue push.
module tsfa_front #(
	parameter int SAMPLE_BITS = tsfa_pkg::SampleBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	tsfa_in_if.sink            smp,
	input  logic               q_full,
	output tsfa_pkg::q_entry_t q_push
);

	localparam int CW = tsfa_pkg::CodeW;
	localparam logic [CW-1:0] SampleMask = CW'((32'd1 << SAMPLE_BITS) - 32'd1);

	logic [CW-1:0] dly_q [4];
	logic [CW-1:0] last_q;
	logic [CW-1:0] x;
	logic [tsfa_pkg::SumW-1:0] sum;
	logic [tsfa_pkg::ProdW-1:0] prod;
	logic [CW-1:0] v;
	logic accept;

	assign smp.ready = !q_full;
	assign accept = smp.valid && smp.ready;

	always_comb begin
		x = smp.sample_valid ? (smp.sample & SampleMask) : last_q;
		sum = tsfa_pkg::SumW'(tsfa_pkg::TapOuter)
				* (tsfa_pkg::SumW'(x) + tsfa_pkg::SumW'(dly_q[3]))
			+ tsfa_pkg::SumW'(tsfa_pkg::TapInner)
				* (tsfa_pkg::SumW'(dly_q[0]) + tsfa_pkg::SumW'(dly_q[2]))
			+ tsfa_pkg::SumW'(tsfa_pkg::TapMid) * tsfa_pkg::SumW'(dly_q[1]);
		prod = tsfa_pkg::ProdW'(sum) * tsfa_pkg::ProdW'(tsfa_pkg::FirRecip);
		v = prod[tsfa_pkg::FirShift +: CW];
	end

	assign q_push.valid = accept && smp.sample_valid;
	assign q_push.code = v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) dly_q[i] <= '0;
			last_q <= '0;
		end else if (accept) begin
			dly_q[3] <= dly_q[2];
			dly_q[2] <= dly_q[1];
			dly_q[1] <= dly_q[0];
			dly_q[0] <= x;
			last_q <= v;
		end
	end

endmodule

// ===== hw/rtl/tsfa_queue.sv =====
// Small FIFO of filtered codes between the front end and the scaling pipeline.
module tsfa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tsfa_pkg::q_entry_t push,
	input  logic               pop,
	output tsfa_pkg::q_entry_t head,
	output logic               full
);

	localparam int Depth = tsfa_pkg::QDepth;
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	logic [tsfa_pkg::CodeW-1:0] mem [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CntW'(Depth));
	assign head.valid = (cnt_q != '0);
	assign head.code = mem[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/tsfa_back.sv =====
// Back end: tenths scaling, alarm compare, decimal split and output register.
module tsfa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tsfa_pkg::q_entry_t head,
	output logic               pop,
	tsfa_cfg_if.sink           cfg,
	tsfa_out_if.source         res
);

	localparam int CW = tsfa_pkg::CodeW;
	localparam int TW = tsfa_pkg::TenthsW;
	localparam int DW = tsfa_pkg::DigitW;

	logic [CW-1:0] limit_q;
	logic vld_s1, vld_s2;
	logic adv_s1, adv_s2;
	logic [CW-1:0] code_s1;
	logic hi_s1;
	logic [tsfa_pkg::ProdW-1:0] prod_s1;
	logic [tsfa_pkg::SumW-1:0] n;
	logic [tsfa_pkg::ProdW-1:0] prod;

	logic [TW-1:0] tenths;
	logic [15:0] hund_p;
	logic [DW-1:0] hund;
	logic [6:0] rem;
	logic [14:0] tens_p;
	logic [DW-1:0] tens;
	logic [DW-1:0] units;

	logic [CW-1:0] code_s2;
	logic [TW-1:0] tenths_s2;
	logic [DW-1:0] hund_s2, tens_s2, units_s2;
	logic hi_s2;

	assign cfg.ready = 1'b1;

	assign adv_s2 = !vld_s2 || res.ready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign pop = adv_s1 && head.valid;

	always_comb begin
		n = tsfa_pkg::SumW'(tsfa_pkg::TempScale) * tsfa_pkg::SumW'(head.code)
			+ tsfa_pkg::SumW'(tsfa_pkg::TempOffset);
		prod = tsfa_pkg::ProdW'(n) * tsfa_pkg::ProdW'(tsfa_pkg::TempRecip);
	end

	always_comb begin
		tenths = prod_s1[tsfa_pkg::TempShift +: TW];
		hund_p = 16'(tenths) * 16'(tsfa_pkg::HundRecip);
		hund = DW'(hund_p >> tsfa_pkg::HundShift);
		rem = 7'(tenths - TW'(hund) * TW'(100));
		tens_p = 15'(rem) * 15'(tsfa_pkg::TensRecip);
		tens = DW'(tens_p >> tsfa_pkg::TensShift);
		units = DW'(rem - 7'(tens) * 7'(10));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tsfa_pkg::AlarmLimitRst;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg.valid) limit_q <= cfg.data;
			if (adv_s1) vld_s1 <= head.valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && head.valid) begin
			code_s1 <= head.code;
			prod_s1 <= prod;
			hi_s1 <= (head.code > limit_q);
		end
		if (adv_s2 && vld_s1) begin
			code_s2 <= code_s1;
			tenths_s2 <= tenths;
			hund_s2 <= hund;
			tens_s2 <= tens;
			units_s2 <= units;
			hi_s2 <= hi_s1;
		end
	end

	assign res.valid = vld_s2;
	assign res.filtered_code = code_s2;
	assign res.temp_tenths = tenths_s2;
	assign res.digit_hundreds = hund_s2;
	assign res.digit_tens = tens_s2;
	assign res.digit_units = units_s2;
	assign res.high_temp = hi_s2;

endmodule

// ===== hw/rtl/temp_sample_fir_scale_alarm_unit.sv =====
// Top level: temperature FIR, tenths scaling, decimal digits and high-temperature flag.
// Throughput: one sample beat per cycle unless the queue is full.
// Invalid samples update the filter and give no result; a stalled output holds back result beats.
// The FIR and divide by 100 run in the accept cycle; a 4-entry queue decouples the 2-stage scaler.
// Reset clears the delay line, last filtered code, queue and pipeline valids, limit to 15000.
module temp_sample_fir_scale_alarm_unit #(
	parameter int SAMPLE_BITS = tsfa_pkg::SampleBitsDef
) (
	input  logic       clk,
	input  logic       arst_n,
	tsfa_in_if.sink    smp,
	tsfa_cfg_if.sink   cfg,
	tsfa_out_if.source res
);

	tsfa_pkg::q_entry_t q_push;
	tsfa_pkg::q_entry_t q_head;
	logic q_full;
	logic q_pop;

	tsfa_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.q_full (q_full),
		.q_push (q_push)
	);

	tsfa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full)
	);

	tsfa_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.cfg    (cfg),
		.res    (res)
	);

endmodule

// ===== hw/rtl/tsfa_checker.sv =====
// Port-level assertions for the temperature filter block, bound to the top level.
module tsfa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [tsfa_pkg::CodeW-1:0]   filtered_code,
	input logic [tsfa_pkg::TenthsW-1:0] temp_tenths,
	input logic [tsfa_pkg::DigitW-1:0]  digit_hundreds,
	input logic [tsfa_pkg::DigitW-1:0]  digit_tens,
	input logic [tsfa_pkg::DigitW-1:0]  digit_units,
	input logic                         high_temp,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [tsfa_pkg::CodeW-1:0]   cfg_data
);

	logic [tsfa_pkg::CodeW-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tsfa_pkg::AlarmLimitRst;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(filtered_code)
			&& $stable(temp_tenths) && $stable(high_temp))
		else $error("result beat changed while stalled");

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> digit_tens <= 4'd9 && digit_units <= 4'd9
			&& 14'(temp_tenths) == 14'(digit_hundreds) * 14'd100
				+ 14'(digit_tens) * 14'd10 + 14'(digit_units))
		else $error("decimal digits do not match tenths");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> temp_tenths >= 10'd249 && temp_tenths <= 10'd512)
		else $error("tenths out of range");

	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> high_temp == (filtered_code > limit_q))
		else $error("alarm flag disagrees with limit");

endmodule

bind temp_sample_fir_scale_alarm_unit tsfa_checker u_tsfa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.filtered_code  (res.filtered_code),
	.temp_tenths    (res.temp_tenths),
	.digit_hundreds (res.digit_hundreds),
	.digit_tens     (res.digit_tens),
	.digit_units    (res.digit_units),
	.high_temp      (res.high_temp),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready),
	.cfg_data       (cfg.data)
);
